### design/itp_pkg.sv
// itp_pkg: shared types, codes and precedence tables for the infix to postfix converter.
// No dependencies; used by itp_stack and infix_to_postfix_converter.
`default_nettype none

package itp_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int VALUE_W         = 32;
    localparam int S_TDATA_W       = 40;
    localparam int S_TUSER_W       = 2;
    localparam int M_TDATA_W       = 40;
    localparam int M_TUSER_W       = 3;

    typedef logic [1:0] opcode_t;
    typedef logic [2:0] op_code_t;
    typedef logic [1:0] err_code_t;

    localparam opcode_t OPC_NUMBER = 2'd0;
    localparam opcode_t OPC_OPER   = 2'd1;
    localparam opcode_t OPC_END    = 2'd2;

    localparam op_code_t OP_ADD   = 3'd0;
    localparam op_code_t OP_SUB   = 3'd1;
    localparam op_code_t OP_MUL   = 3'd2;
    localparam op_code_t OP_DIV   = 3'd3;
    localparam op_code_t OP_OPEN  = 3'd4;
    localparam op_code_t OP_CLOSE = 3'd5;

    localparam err_code_t ERR_NONE     = 2'd0;
    localparam err_code_t ERR_PAREN    = 2'd1;
    localparam err_code_t ERR_OVERFLOW = 2'd2;

    localparam logic [1:0] PREC_TAB [4] = '{2'd1, 2'd1, 2'd2, 2'd2};
    localparam logic       LEFT_TAB [4] = '{1'b0, 1'b1, 1'b0, 1'b1};

    typedef struct packed {
        logic     push;
        logic     pop;
        op_code_t wdata;
    } stk_ctl_t;

    // stacked operator leaves before an incoming arithmetic operator
    function automatic logic op_pops(op_code_t stacked, op_code_t incoming);
        logic [1:0] ps;
        logic [1:0] pi;
        ps = PREC_TAB[stacked[1:0]];
        pi = PREC_TAB[incoming[1:0]];
        return !stacked[2] && ((ps > pi) || ((ps == pi) && LEFT_TAB[stacked[1:0]]));
    endfunction

endpackage

`default_nettype wire

### design/infix_to_postfix_converter.sv
// infix_to_postfix_converter: shunting-yard token reorder, top level with control FSM
// and output register. Depends on itp_pkg and itp_stack.
//
//   channel | dir | tdata                                   | tuser                    | tlast
//   s_      | in  | [31:0] number_value [34:32] operator_code | [1:0] opcode             | -
//   m_      | out | [31:0] out_value [33:32] out_operator    | [0] is_number [2:1] error | last_of_run
//
// Number: result register loaded on accept when free, else once free; valid on the next cycle.
// Operator: pops leaving operators, then pushes or flags overflow; open paren: pushed unless full.
// Close paren: pops entries down to and including the matching open (error if none).
// End: pops every stacked entry, one per cycle unless an output stall holds it, then flags unclosed parens.
// Reset clears control, stack count and output valid; stack memory is not cleared.
// An output stall freezes operator pops; one token is in work at a time.
`default_nettype none

module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [itp_pkg::S_TDATA_W-1:0]    s_tdata,   // number_value, operator_code
    input  wire logic [itp_pkg::S_TUSER_W-1:0]    s_tuser,   // opcode
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [itp_pkg::M_TDATA_W-1:0]         m_tdata,   // out_value, out_operator
    output logic [itp_pkg::M_TUSER_W-1:0]         m_tuser,   // is_number, error_code
    output logic                                  m_tlast
);
    import itp_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NUM,
        ST_OPER,
        ST_OVF,
        ST_CLOSE,
        ST_FLUSH
    } state_t;

    state_t                     state_reg, state_next;
    op_code_t                   code_reg, code_next;
    logic signed [VALUE_W-1:0]  value_reg, value_next;
    logic                       unclosed_reg, unclosed_next;
    logic [CW-1:0]              open_cnt_reg, open_cnt_next;

    logic                       m_valid_reg;
    logic signed [VALUE_W-1:0]  m_value_reg;
    logic [1:0]                 m_oper_reg;
    logic                       m_isnum_reg;
    err_code_t                  m_err_reg;
    logic                       m_last_reg;

    logic                       emit;
    logic                       e_isnum;
    logic signed [VALUE_W-1:0]  e_value;
    logic [1:0]                 e_oper;
    err_code_t                  e_err;
    logic                       e_last;

    stk_ctl_t                   stk_ctl;
    op_code_t                   stk_top;
    op_code_t                   stk_below;
    logic [CW-1:0]              stk_count;

    opcode_t                    in_opcode;
    op_code_t                   in_code;
    logic signed [VALUE_W-1:0]  in_value;
    logic                       in_fire;
    logic                       out_free;
    logic                       stk_full;

    itp_stack #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (stk_ctl),
        .top     (stk_top),
        .below   (stk_below),
        .count   (stk_count)
    );

    assign in_opcode = s_tuser[1:0];
    assign in_code   = s_tdata[VALUE_W+2:VALUE_W];
    assign in_value  = $signed(s_tdata[VALUE_W-1:0]);
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign stk_full  = (stk_count == CW'(STACK_DEPTH));

    always_comb begin
        state_next    = state_reg;
        code_next     = code_reg;
        value_next    = value_reg;
        unclosed_next = unclosed_reg;
        open_cnt_next = open_cnt_reg;
        stk_ctl       = '0;
        emit          = 1'b0;
        e_isnum       = 1'b0;
        e_value       = '0;
        e_oper        = 2'd0;
        e_err         = ERR_NONE;
        e_last        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    value_next = in_value;
                    code_next  = in_code;
                    case (in_opcode)
                        OPC_NUMBER: begin
                            if (out_free) begin
                                emit    = 1'b1;
                                e_isnum = 1'b1;
                                e_value = in_value;
                                e_last  = 1'b1;
                            end else begin
                                state_next = ST_NUM;
                            end
                        end
                        OPC_OPER: begin
                            case (in_code)
                                OP_ADD, OP_SUB, OP_MUL, OP_DIV: state_next = ST_OPER;
                                OP_OPEN: begin
                                    if (stk_full) begin
                                        state_next = ST_OVF;
                                    end else begin
                                        stk_ctl.push  = 1'b1;
                                        stk_ctl.wdata = OP_OPEN;
                                        open_cnt_next = open_cnt_reg + CW'(1);
                                    end
                                end
                                OP_CLOSE: state_next = ST_CLOSE;
                                default: ;
                            endcase
                        end
                        OPC_END: begin
                            unclosed_next = (open_cnt_reg != '0);
                            state_next    = ST_FLUSH;
                        end
                        default: ;
                    endcase
                end
            end

            ST_NUM: begin
                if (out_free) begin
                    emit       = 1'b1;
                    e_isnum    = 1'b1;
                    e_value    = value_reg;
                    e_last     = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_OPER: begin
                if ((stk_count != '0) && op_pops(stk_top, code_reg)) begin
                    if (out_free) begin
                        emit        = 1'b1;
                        e_oper      = stk_top[1:0];
                        e_last      = !((stk_count > CW'(1)) && op_pops(stk_below, code_reg));
                        stk_ctl.pop = 1'b1;
                    end
                end else if (stk_full) begin
                    state_next = ST_OVF;
                end else begin
                    stk_ctl.push  = 1'b1;
                    stk_ctl.wdata = code_reg;
                    state_next    = ST_IDLE;
                end
            end

            ST_OVF: begin
                if (out_free) begin
                    emit       = 1'b1;
                    e_err      = ERR_OVERFLOW;
                    e_last     = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_CLOSE: begin
                if (stk_count == '0) begin
                    if (out_free) begin
                        emit       = 1'b1;
                        e_err      = ERR_PAREN;
                        e_last     = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else if (stk_top == OP_OPEN) begin
                    stk_ctl.pop   = 1'b1;
                    open_cnt_next = open_cnt_reg - CW'(1);
                    state_next    = ST_IDLE;
                end else if (out_free) begin
                    emit        = 1'b1;
                    e_oper      = stk_top[1:0];
                    e_last      = (stk_count > CW'(1)) && (stk_below == OP_OPEN);
                    stk_ctl.pop = 1'b1;
                end
            end

            ST_FLUSH: begin
                if (stk_count == '0) begin
                    if (!unclosed_reg) begin
                        state_next = ST_IDLE;
                    end else if (out_free) begin
                        emit       = 1'b1;
                        e_err      = ERR_PAREN;
                        e_last     = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else if (stk_top == OP_OPEN) begin
                    stk_ctl.pop   = 1'b1;
                    open_cnt_next = open_cnt_reg - CW'(1);
                end else if (out_free) begin
                    emit        = 1'b1;
                    e_oper      = stk_top[1:0];
                    e_last      = (stk_count == CW'(1)) && !unclosed_reg;
                    stk_ctl.pop = 1'b1;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            unclosed_reg <= 1'b0;
            open_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            unclosed_reg <= unclosed_next;
            open_cnt_reg <= open_cnt_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        code_reg  <= code_next;
        value_reg <= value_next;
        if (emit) begin
            m_isnum_reg <= e_isnum;
            m_value_reg <= e_value;
            m_oper_reg  <= e_oper;
            m_err_reg   <= e_err;
            m_last_reg  <= e_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - VALUE_W - 2){1'b0}}, m_oper_reg, m_value_reg};
    assign m_tuser  = {m_err_reg, m_isnum_reg};
    assign m_tlast  = m_last_reg;

`ifndef NO_ASSERTIONS
    a_open_within_count: assert property (@(posedge aclk) disable iff (!aresetn)
        open_cnt_reg <= stk_count)
        else $error("open paren count exceeds stack count");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stk_count <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_push_pop_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(stk_ctl.push && stk_ctl.pop))
        else $error("push and pop in the same cycle");

    a_err_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_err_reg != ERR_NONE)) |->
            (!m_isnum_reg && (m_oper_reg == 2'd0) && (m_value_reg == '0) && m_last_reg))
        else $error("error transfer carries payload or is not last");

    a_flush_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_FLUSH) && (state_next == ST_IDLE)) |=> (stk_count == '0))
        else $error("stack not empty after end of expression");
`endif

endmodule

`default_nettype wire

### design/itp_stack.sv
// itp_stack: operator stack in a synchronous memory with registered top and
// next-to-top reads, write-to-read forwarding on push. Depends on itp_pkg.
`default_nettype none

module itp_stack #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire itp_pkg::stk_ctl_t                  ctl,
    output logic [2:0]                              top,
    output logic [2:0]                              below,
    output logic [$clog2(STACK_DEPTH+1)-1:0]        count
);
    import itp_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    op_code_t        mem [STACK_DEPTH];
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [CW-1:0]   top_idx;
    logic [CW-1:0]   below_idx;
    logic [AW-1:0]   waddr;
    logic [AW-1:0]   raddr_top;
    logic [AW-1:0]   raddr_below;
    op_code_t        top_reg;
    op_code_t        below_reg;

    always_comb begin
        count_next = count_reg;
        if (ctl.push) begin
            count_next = count_reg + CW'(1);
        end else if (ctl.pop) begin
            count_next = count_reg - CW'(1);
        end
        top_idx     = count_next - CW'(1);
        below_idx   = count_next - CW'(2);
        raddr_top   = top_idx[AW-1:0];
        raddr_below = below_idx[AW-1:0];
        waddr       = count_reg[AW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.push) begin
            mem[waddr] <= ctl.wdata;
        end
        top_reg   <= (ctl.push && (waddr == raddr_top))   ? ctl.wdata : mem[raddr_top];
        below_reg <= (ctl.push && (waddr == raddr_below)) ? ctl.wdata : mem[raddr_below];
    end

    assign top   = top_reg;
    assign below = below_reg;
    assign count = count_reg;

endmodule

`default_nettype wire

### tb/sv/infix_to_postfix_converter_tb.sv
// Self-checking testbench for infix_to_postfix_converter: a directed token table, then
// random expressions, deep nests and noise, all checked against a shunting-yard predictor.
// Depends on itp_pkg and the converter RTL.
`timescale 1ns / 100ps

module infix_to_postfix_converter_tb;
    import itp_pkg::*;

    localparam int       STACK_DEPTH = STACK_DEPTH_DEF;
    localparam int       ITEMS       = 300;
    localparam int       LONG_HOLD   = 400;
    localparam int       TAIL_CYCLES = 40;
    localparam opcode_t  OPC_UNUSED  = 2'd3;
    localparam op_code_t OP_RSVD_LO  = 3'd6;
    localparam op_code_t OP_RSVD_HI  = 3'd7;

    typedef struct packed {
        logic        is_number;
        logic [31:0] value;
        logic [1:0]  oper;
        err_code_t   err;
        logic        last;
    } postfix_tok_t;

    typedef struct packed {
        opcode_t      opc;
        logic [31:0]  value;
        op_code_t     code;
        logic         fixed;
        logic         n_fixed;
        postfix_tok_t want;
    } stim_row_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;    // [31:0] number_value, [34:32] operator_code
    logic [S_TUSER_W-1:0] s_tuser  = '0;    // [1:0] opcode
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // [31:0] out_value, [33:32] out_operator
    logic [M_TUSER_W-1:0] m_tuser;          // [0] is_number, [2:1] error_code
    logic                 m_tlast;

    // expectation that travels with the item in flight
    logic         row_fixed   = 1'b0;
    logic         row_n_fixed = 1'b0;
    postfix_tok_t row_want    = '0;

    op_code_t     op_stack [STACK_DEPTH];
    int           stk_depth    = 0;
    postfix_tok_t postfix_q [$];
    postfix_tok_t held_tok;
    logic         held_valid   = 1'b0;
    int           mismatches   = 0;
    int           results_seen = 0;
    int           sent_items   = 0;
    int           burst_left   = 0;
    logic         hold_done    = 1'b0;
    stim_row_t    dir_rows [$];

    infix_to_postfix_converter #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always #2 aclk = ~aclk;

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ---------------- predictor ----------------

    // the newest token is held back so that it can be marked last at the end of the run
    task automatic emit(input logic isnum, input logic [31:0] v, input logic [1:0] op,
                        input err_code_t e);
        if (held_valid) postfix_q.push_back(held_tok);
        held_tok.is_number = isnum;
        held_tok.value     = v;
        held_tok.oper      = op;
        held_tok.err       = e;
        held_tok.last      = 1'b0;
        held_valid         = 1'b1;
    endtask

    task automatic push_or_flag(input op_code_t code);
        if (stk_depth >= STACK_DEPTH) begin
            emit(1'b0, '0, 2'd0, ERR_OVERFLOW);
        end else begin
            op_stack[stk_depth] = code;
            stk_depth++;
        end
    endtask

    task automatic shunt_token(input opcode_t opc, input logic [31:0] v, input op_code_t code);
        op_code_t top;
        logic     done;
        logic     unclosed;
        done     = 1'b0;
        unclosed = 1'b0;
        case (opc)
            OPC_NUMBER: begin
                emit(1'b1, v, 2'd0, ERR_NONE);
            end
            OPC_OPER: begin
                if (code <= OP_DIV) begin
                    while (stk_depth > 0 && !done) begin
                        top = op_stack[stk_depth-1];
                        if (top >= OP_OPEN ||
                            !(PREC_TAB[top[1:0]] > PREC_TAB[code[1:0]] ||
                              (PREC_TAB[top[1:0]] == PREC_TAB[code[1:0]] &&
                               LEFT_TAB[top[1:0]]))) begin
                            done = 1'b1;
                        end else begin
                            stk_depth--;
                            emit(1'b0, '0, top[1:0], ERR_NONE);
                        end
                    end
                    push_or_flag(code);
                end else if (code == OP_OPEN) begin
                    push_or_flag(code);
                end else if (code == OP_CLOSE) begin
                    while (stk_depth > 0 && !done) begin
                        top = op_stack[stk_depth-1];
                        stk_depth--;
                        if (top == OP_OPEN) done = 1'b1;
                        else emit(1'b0, '0, top[1:0], ERR_NONE);
                    end
                    if (!done) emit(1'b0, '0, 2'd0, ERR_PAREN);
                end
            end
            OPC_END: begin
                while (stk_depth > 0) begin
                    top = op_stack[stk_depth-1];
                    stk_depth--;
                    if (top < OP_OPEN) emit(1'b0, '0, top[1:0], ERR_NONE);
                    else unclosed = 1'b1;
                end
                if (unclosed) emit(1'b0, '0, 2'd0, ERR_PAREN);
            end
            default: ;
        endcase
        if (held_valid) begin
            held_tok.last = 1'b1;
            postfix_q.push_back(held_tok);
            held_valid = 1'b0;
        end
    endtask

    // ---------------- checking ----------------

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("ERROR @%0t %s: expected %0h, got %0h", $time, what, want, got);
        mismatches++;
    endtask

    task automatic take_token();
        int q_size_pre;
        q_size_pre = postfix_q.size();
        shunt_token(s_tuser, s_tdata[31:0], s_tdata[34:32]);
        if (row_fixed) begin
            while (postfix_q.size() > q_size_pre) void'(postfix_q.pop_back());
            if (row_n_fixed) postfix_q.push_back(row_want);
        end
    endtask

    task automatic check_result();
        postfix_tok_t w;
        results_seen++;
        if (postfix_q.size() == 0) begin
            report_mismatch("result with nothing pending", '0, m_tdata[31:0]);
        end else begin
            w = postfix_q.pop_front();
            if (m_tuser[0] !== w.is_number)    report_mismatch("is_number", w.is_number, m_tuser[0]);
            if (m_tdata[31:0] !== w.value)     report_mismatch("out_value", w.value, m_tdata[31:0]);
            if (m_tdata[33:32] !== w.oper)     report_mismatch("out_operator", w.oper, m_tdata[33:32]);
            if (m_tuser[2:1] !== w.err)        report_mismatch("error_code", w.err, m_tuser[2:1]);
            if (m_tlast !== w.last)            report_mismatch("last_of_run", w.last, m_tlast);
        end
    endtask

    // input side is predicted before output side is checked, so pass-through is safe
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) take_token();
            if (m_tvalid && m_tready) check_result();
        end
    end

    // ---------------- receiver ----------------

    initial begin
        int mode;
        int span;
        int i;
        forever begin
            if (!hold_done && results_seen >= 60) begin
                hold_done = 1'b1;
                repeat (LONG_HOLD) begin
                    @(posedge aclk);
                    m_tready <= 1'b0;
                end
            end
            mode = $urandom_range(0, 2);
            span = $urandom_range(8, 64);
            for (i = 0; i < span; i++) begin
                @(posedge aclk);
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 9) > 2);
                    default: m_tready <= (i % 4 == 3);
                endcase
            end
        end
    end

    // ---------------- stimulus ----------------

    function automatic postfix_tok_t mk_tok(input logic isnum, input logic [31:0] v,
                                            input logic [1:0] op, input err_code_t e);
        postfix_tok_t t;
        t.is_number = isnum;
        t.value     = v;
        t.oper      = op;
        t.err       = e;
        t.last      = 1'b1;
        return t;
    endfunction

    function automatic stim_row_t mk_row(input opcode_t opc, input logic [31:0] v,
                                         input op_code_t code, input logic fixed,
                                         input logic n_fixed, input postfix_tok_t want);
        stim_row_t r;
        r.opc     = opc;
        r.value   = v;
        r.code    = code;
        r.fixed   = fixed;
        r.n_fixed = n_fixed;
        r.want    = want;
        return r;
    endfunction

    function automatic logic [31:0] pick_number();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic drive_row(input stim_row_t r);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 60 : 10);
        end
        burst_left--;
        s_tvalid    <= 1'b1;
        s_tdata     <= {5'b0, r.code, r.value};
        s_tuser     <= r.opc;
        row_fixed   <= r.fixed;
        row_n_fixed <= r.n_fixed;
        row_want    <= r.want;
        do @(posedge aclk); while (!s_tready);
        if (r.opc != OPC_UNUSED && !(r.opc == OPC_OPER && r.code > OP_CLOSE)) sent_items++;
    endtask

    task automatic send_token(input opcode_t opc, input logic [31:0] v, input op_code_t code);
        drive_row(mk_row(opc, v, code, 1'b0, 1'b0, '0));
    endtask

    // well-formed expression with random content; a few leave parens open or add a stray close
    task automatic gen_expression();
        int depth;
        int terms;
        int n_terms;
        int flavor;
        depth   = 0;
        terms   = 0;
        n_terms = $urandom_range(1, 8);
        flavor  = $urandom_range(0, 19);
        do begin
            while (depth < 5 && $urandom_range(0, 3) == 0) begin
                send_token(OPC_OPER, $urandom, OP_OPEN);
                depth++;
            end
            send_token(OPC_NUMBER, pick_number(), op_code_t'($urandom_range(0, 7)));
            terms++;
            while (depth > 0 && $urandom_range(0, 2) == 0) begin
                send_token(OPC_OPER, $urandom, OP_CLOSE);
                depth--;
            end
            if (terms < n_terms) send_token(OPC_OPER, $urandom, op_code_t'($urandom_range(0, 3)));
        end while (terms < n_terms);
        if (flavor != 0) begin
            while (depth > 0) begin
                send_token(OPC_OPER, $urandom, OP_CLOSE);
                depth--;
            end
        end
        if (flavor == 1) send_token(OPC_OPER, $urandom, OP_CLOSE);
        send_token(OPC_END, $urandom, op_code_t'($urandom_range(0, 7)));
    endtask

    // drives the operator stack toward and possibly past its depth
    task automatic gen_deep_nest();
        repeat ($urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 4)) begin
            if ($urandom_range(0, 3) != 0) begin
                send_token(OPC_OPER, $urandom, OP_OPEN);
            end else begin
                send_token(OPC_NUMBER, pick_number(), op_code_t'($urandom_range(0, 7)));
                send_token(OPC_OPER, $urandom, op_code_t'($urandom_range(0, 3)));
            end
        end
        repeat ($urandom_range(0, 3)) send_token(OPC_OPER, $urandom, OP_CLOSE);
        send_token(OPC_END, $urandom, op_code_t'($urandom_range(0, 7)));
    endtask

    initial begin
        int start;
        int pick;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        //                        opcode      value         code        fix   one   expected
        dir_rows.push_back(mk_row(OPC_OPER,   32'h0,        OP_CLOSE,   1'b1, 1'b1,
                                  mk_tok(1'b0, 32'h0, 2'd0, ERR_PAREN)));
        dir_rows.push_back(mk_row(OPC_NUMBER, 32'h7FFF_FFFF, OP_RSVD_HI, 1'b1, 1'b1,
                                  mk_tok(1'b1, 32'h7FFF_FFFF, 2'd0, ERR_NONE)));
        dir_rows.push_back(mk_row(OPC_NUMBER, 32'h8000_0000, OP_ADD,    1'b1, 1'b1,
                                  mk_tok(1'b1, 32'h8000_0000, 2'd0, ERR_NONE)));
        dir_rows.push_back(mk_row(OPC_UNUSED, 32'hFFFF_FFFF, OP_RSVD_HI, 1'b1, 1'b0, '0));
        dir_rows.push_back(mk_row(OPC_OPER,   32'h0,        OP_RSVD_LO, 1'b1, 1'b0, '0));
        dir_rows.push_back(mk_row(OPC_OPER,   32'h0,        OP_RSVD_HI, 1'b1, 1'b0, '0));
        dir_rows.push_back(mk_row(OPC_END,    32'h0,        OP_ADD,     1'b1, 1'b0, '0));
        // 7 - 4 - 5 * 6 / ( 2 + 1 )
        dir_rows.push_back(mk_row(OPC_NUMBER, 32'd7,        OP_ADD,     1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(OPC_OPER,   32'h0,        OP_SUB,     1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(OPC_NUMBER, 32'd4,        OP_ADD,     1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(OPC_OPER,   32'h0,        OP_SUB,     1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(OPC_NUMBER, 32'd5,        OP_ADD,     1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(OPC_OPER,   32'h0,        OP_MUL,     1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(OPC_NUMBER, 32'd6,        OP_ADD,     1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(OPC_OPER,   32'h0,        OP_DIV,     1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(OPC_OPER,   32'h0,        OP_OPEN,    1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(OPC_NUMBER, 32'd2,        OP_ADD,     1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(OPC_OPER,   32'h0,        OP_ADD,     1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(OPC_NUMBER, 32'd1,        OP_ADD,     1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(OPC_OPER,   32'h0,        OP_CLOSE,   1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(OPC_END,    32'h0,        OP_ADD,     1'b0, 1'b0, '0));
        // open left at end
        dir_rows.push_back(mk_row(OPC_OPER,   32'h0,        OP_OPEN,    1'b1, 1'b0, '0));
        dir_rows.push_back(mk_row(OPC_END,    32'h0,        OP_ADD,     1'b1, 1'b1,
                                  mk_tok(1'b0, 32'h0, 2'd0, ERR_PAREN)));
        // close with an operator stacked but no open
        dir_rows.push_back(mk_row(OPC_NUMBER, 32'd9,        OP_ADD,     1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(OPC_OPER,   32'h0,        OP_ADD,     1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(OPC_OPER,   32'h0,        OP_CLOSE,   1'b0, 1'b0, '0));

        foreach (dir_rows[i]) drive_row(dir_rows[i]);

        start = sent_items;
        while (sent_items - start < ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick < 12) begin
                gen_expression();
            end else if (pick < 15) begin
                gen_deep_nest();
            end else begin
                repeat ($urandom_range(1, 5))
                    send_token(opcode_t'($urandom_range(0, 3)), $urandom,
                               op_code_t'($urandom_range(0, 7)));
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (postfix_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### sim.f
design/itp_pkg.sv
design/itp_stack.sv
design/infix_to_postfix_converter.sv
tb/sv/infix_to_postfix_converter_tb.sv
